// File: rtl/core/crmt_pkg.sv
// Shared constants, codes and types of the CAN receive mailbox table.
package crmt_pkg;

  localparam int MAILBOX_ENTRIES = 16;
  localparam int IDX_W = (MAILBOX_ENTRIES > 1) ? $clog2(MAILBOX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAILBOX_ENTRIES + 1);

  localparam int ID_W = 29;
  localparam int LEN_W = 4;
  localparam int DATA_W = 64;
  localparam int PAY_W = LEN_W + DATA_W;

  localparam int S_TDATA_W = 104;
  localparam int M_TDATA_W = 72;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(8);

  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_READ_NEW    = 3'd0,
    ST_READ_REPEAT = 3'd1,
    ST_UNKNOWN     = 3'd2,
    ST_UPDATED     = 3'd3,
    ST_ADDED       = 3'd4,
    ST_FULL        = 3'd5
  } status_e;

  typedef struct packed {
    logic             done;
    logic             hit;
    logic [IDX_W-1:0] slot;
  } scan_res_t;

endpackage

// File: rtl/core/crmt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module crmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/crmt_scan.sv
// Identifier store and the shared compare unit that scans it one entry per cycle.
module crmt_scan
  import crmt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ID_W-1:0]  key_i,
  input  logic [CNT_W-1:0] fill_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  logic [ID_W-1:0]  wident_i,
  output scan_res_t        res_o
);

  logic             busy_q;
  logic [CNT_W-1:0] addr_q;
  logic             pend_q;
  logic [IDX_W-1:0] pend_idx_q;
  scan_res_t        res_q;
  logic [ID_W-1:0]  ident_rd;
  logic             hit_now;
  logic             last;
  logic             done;
  logic             issue;

  crmt_ram #(
    .WIDTH(ID_W),
    .DEPTH(MAILBOX_ENTRIES)
  ) u_ident_ram (
    .clk_i  (clk_i),
    .we_i   (we_i),
    .waddr_i(waddr_i),
    .wdata_i(wident_i),
    .re_i   (issue),
    .raddr_i(addr_q[IDX_W-1:0]),
    .rdata_o(ident_rd)
  );

  always_comb begin
    hit_now = pend_q && (ident_rd == key_i);
    last    = (addr_q == fill_i);
    done    = busy_q && (hit_now || last);
    issue   = busy_q && !hit_now && !last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      addr_q     <= '0;
      pend_q     <= 1'b0;
      pend_idx_q <= '0;
      res_q      <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      addr_q <= '0;
      pend_q <= 1'b0;
      res_q  <= '0;
    end else begin
      pend_q     <= issue;
      pend_idx_q <= addr_q[IDX_W-1:0];
      if (issue) begin
        addr_q <= addr_q + CNT_W'(1);
      end
      if (done) begin
        busy_q <= 1'b0;
      end
      res_q.done <= done;
      res_q.hit  <= hit_now;
      res_q.slot <= pend_idx_q;
    end
  end

  assign res_o = res_q;

endmodule

// File: rtl/core/can_receive_mailbox_table.sv
// Top level: CAN receive mailbox table with identifier scan and fresh flags.
// A miss is reported once the scan has compared every filled mailbox, and a hit as soon as the
// matching slot is compared; the scan reads one mailbox per cycle. The next beat is taken the
// cycle after the result is loaded into the output register, so only one item is in flight,
// and an earlier result that is stalled on the output holds off that load.
// Reset empties the table and clears all fresh flags at once; no clearing pass.
module can_receive_mailbox_table
  import crmt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // msg_id [28:0], frame_length [32:29], frame_data [96:33], zero fill
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // command [0]
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // out_length [3:0], out_data [67:4]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // status [2:0]
  output logic [2:0]           m_axis_tuser
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_OUT
  } state_e;

  state_e                     state_q;
  logic                       cmd_q;
  logic [ID_W-1:0]            key_q;
  logic [LEN_W-1:0]           len_q;
  logic [DATA_W-1:0]          data_q;
  logic [CNT_W-1:0]           fill_q;
  logic [MAILBOX_ENTRIES-1:0] fresh_q;
  logic                       rd_hit_q;
  status_e                    status_q;
  logic                       m_valid_q;
  status_e                    out_status_q;
  logic [LEN_W-1:0]           out_len_q;
  logic [DATA_W-1:0]          out_data_q;

  logic             accept;
  logic [LEN_W-1:0] in_len;
  logic [LEN_W-1:0] in_len_sat;
  scan_res_t        scan_res;
  logic             table_full;
  logic             id_we;
  logic             pay_we;
  logic [IDX_W-1:0] pay_waddr;
  logic             pay_re;
  logic [PAY_W-1:0] pay_rd;
  logic             out_load;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_len        = s_axis_tdata[ID_W+LEN_W-1:ID_W];
  assign in_len_sat    = (in_len > MAX_LEN) ? MAX_LEN : in_len;
  assign table_full    = (fill_q == CNT_W'(MAILBOX_ENTRIES));
  assign out_load      = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);

  always_comb begin
    id_we     = 1'b0;
    pay_we    = 1'b0;
    pay_re    = 1'b0;
    pay_waddr = scan_res.slot;
    if (state_q == S_SCAN && scan_res.done) begin
      if (cmd_q == CMD_STORE) begin
        if (scan_res.hit) begin
          pay_we = 1'b1;
        end else if (!table_full) begin
          id_we     = 1'b1;
          pay_we    = 1'b1;
          pay_waddr = fill_q[IDX_W-1:0];
        end
      end else begin
        pay_re = scan_res.hit;
      end
    end
  end

  crmt_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .key_i   (key_q),
    .fill_i  (fill_q),
    .we_i    (id_we),
    .waddr_i (fill_q[IDX_W-1:0]),
    .wident_i(key_q),
    .res_o   (scan_res)
  );

  crmt_ram #(
    .WIDTH(PAY_W),
    .DEPTH(MAILBOX_ENTRIES)
  ) u_payload_ram (
    .clk_i  (clk_i),
    .we_i   (pay_we),
    .waddr_i(pay_waddr),
    .wdata_i({data_q, len_q}),
    .re_i   (pay_re),
    .raddr_i(scan_res.slot),
    .rdata_o(pay_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= CMD_STORE;
      key_q        <= '0;
      len_q        <= '0;
      data_q       <= '0;
      fill_q       <= '0;
      fresh_q      <= '0;
      rd_hit_q     <= 1'b0;
      status_q     <= ST_UNKNOWN;
      m_valid_q    <= 1'b0;
      out_status_q <= ST_UNKNOWN;
      out_len_q    <= '0;
      out_data_q   <= '0;
    end else begin
      if (m_valid_q && m_axis_tready && !out_load) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q   <= s_axis_tuser;
            key_q   <= s_axis_tdata[ID_W-1:0];
            len_q   <= in_len_sat;
            data_q  <= s_axis_tdata[ID_W+LEN_W+DATA_W-1:ID_W+LEN_W];
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_res.done) begin
            rd_hit_q <= 1'b0;
            state_q  <= S_OUT;
            if (cmd_q == CMD_STORE) begin
              if (scan_res.hit) begin
                fresh_q[scan_res.slot] <= 1'b1;
                status_q               <= ST_UPDATED;
              end else if (!table_full) begin
                fresh_q[fill_q[IDX_W-1:0]] <= 1'b1;
                fill_q                     <= fill_q + CNT_W'(1);
                status_q                   <= ST_ADDED;
              end else begin
                status_q <= ST_FULL;
              end
            end else begin
              if (scan_res.hit) begin
                rd_hit_q               <= 1'b1;
                fresh_q[scan_res.slot] <= 1'b0;
                status_q <= fresh_q[scan_res.slot] ? ST_READ_NEW : ST_READ_REPEAT;
              end else begin
                status_q <= ST_UNKNOWN;
              end
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            m_valid_q    <= 1'b1;
            out_status_q <= status_q;
            out_len_q    <= rd_hit_q ? pay_rd[LEN_W-1:0] : '0;
            out_data_q   <= rd_hit_q ? pay_rd[PAY_W-1:LEN_W] : '0;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {out_data_q, out_len_q};
  assign m_axis_tuser  = out_status_q;

endmodule

// File: sim/tb_can_receive_mailbox_table.sv
// Testbench for the CAN receive mailbox table: directed and random stream traffic checked against a local model.
module tb_can_receive_mailbox_table;
  import crmt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;

  typedef struct {
    logic             cmd;
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] len;
    logic [DATA_W-1:0] data;
  } frame_item_t;

  typedef struct {
    status_e           status;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
  } mailbox_resp_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tuser = CMD_STORE;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [2:0]           m_axis_tuser;

  frame_item_t      frame_q[$];
  frame_item_t      next_frame;
  mailbox_resp_t    pending_resp_q[$];
  mailbox_resp_t    due_resp;
  logic [ID_W-1:0]  id_pool[$];

  logic              mb_valid [MAILBOX_ENTRIES] = '{default: 1'b0};
  logic [ID_W-1:0]   mb_ident [MAILBOX_ENTRIES];
  logic [LEN_W-1:0]  mb_len   [MAILBOX_ENTRIES];
  logic [DATA_W-1:0] mb_bytes [MAILBOX_ENTRIES];
  logic              mb_fresh [MAILBOX_ENTRIES] = '{default: 1'b0};
  int                mb_count = 0;

  logic in_beat = 1'b0;
  logic calm = 1'b0;
  int   send_gap = 0;
  int   stall_left = 0;
  int   idle_cycles = 0;
  int   err_count = 0;

  can_receive_mailbox_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic mailbox_resp_t mailbox_response(logic cmd, logic [ID_W-1:0] id,
                                                     logic [LEN_W-1:0] len,
                                                     logic [DATA_W-1:0] data);
    mailbox_resp_t r;
    int slot;
    r = '{ST_UNKNOWN, '0, '0};
    slot = -1;
    for (int i = 0; i < MAILBOX_ENTRIES; i++) begin
      if (slot < 0 && mb_valid[i] && mb_ident[i] == id) slot = i;
    end
    if (cmd == CMD_STORE) begin
      if (len > MAX_LEN) len = MAX_LEN;
      if (slot >= 0) begin
        r.status = ST_UPDATED;
      end else if (mb_count >= MAILBOX_ENTRIES) begin
        r.status = ST_FULL;
      end else begin
        slot = mb_count;
        mb_count++;
        mb_valid[slot] = 1'b1;
        mb_ident[slot] = id;
        r.status = ST_ADDED;
      end
      if (slot >= 0) begin
        mb_len[slot] = len;
        mb_bytes[slot] = data;
        mb_fresh[slot] = 1'b1;
      end
    end else if (slot >= 0) begin
      r.len = mb_len[slot];
      r.data = mb_bytes[slot];
      r.status = mb_fresh[slot] ? ST_READ_NEW : ST_READ_REPEAT;
      mb_fresh[slot] = 1'b0;
    end
    return r;
  endfunction

  task automatic add_frame(logic cmd, logic [ID_W-1:0] id, logic [LEN_W-1:0] len,
                           logic [DATA_W-1:0] data);
    frame_item_t item;
    item = '{cmd, id, len, data};
    frame_q.insert(frame_q.size(), item);
    if (cmd == CMD_STORE) id_pool.insert(id_pool.size(), id);
  endtask

  always @(negedge clk_i) begin
    if ($urandom_range(0, 299) == 0) calm <= ~calm;
    if (rst_ni && (!s_axis_tvalid || in_beat)) begin
      if (send_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (frame_q.size() != 0) begin
        next_frame = frame_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'b0, next_frame.data, next_frame.len, next_frame.id};
        s_axis_tuser <= next_frame.cmd;
        send_gap <= pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    in_beat = rst_ni && s_axis_tvalid && s_axis_tready;
    if (in_beat) begin
      pending_resp_q.insert(pending_resp_q.size(),
                            mailbox_response(s_axis_tuser, s_axis_tdata[28:0],
                                             s_axis_tdata[32:29], s_axis_tdata[96:33]));
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_resp_q.size() == 0) begin
        $error("unexpected result: status %0d", m_axis_tuser);
        err_count++;
      end else begin
        due_resp = pending_resp_q.pop_front();
        if (m_axis_tuser !== due_resp.status) begin
          $error("status: expected %0d, got %0d", due_resp.status, m_axis_tuser);
          err_count++;
        end
        if (m_axis_tdata[3:0] !== due_resp.len) begin
          $error("out_length: expected %0d, got %0d", due_resp.len, m_axis_tdata[3:0]);
          err_count++;
        end
        if (m_axis_tdata[67:4] !== due_resp.data) begin
          $error("out_data: expected %h, got %h", due_resp.data, m_axis_tdata[67:4]);
          err_count++;
        end
      end
      idle_cycles = 0;
    end else if (in_beat) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    logic             cmd;
    logic [ID_W-1:0]  id;
    int               r;

    add_frame(CMD_READ, '0, '0, '0);
    add_frame(CMD_STORE, '0, '0, '0);
    add_frame(CMD_READ, '0, '0, '0);
    add_frame(CMD_READ, '0, '0, '0);
    add_frame(CMD_STORE, '1, 4'd8, '1);
    add_frame(CMD_READ, '1, '0, '0);
    add_frame(CMD_STORE, '1, 4'd15, 64'h0123_4567_89ab_cdef);
    add_frame(CMD_READ, '1, 4'd15, '1);
    add_frame(CMD_STORE, 29'h7ff, 4'd9, 64'hfedc_ba98_7654_3210);
    add_frame(CMD_STORE, 29'h7ff, 4'd3, 64'h5555_aaaa_5555_aaaa);
    add_frame(CMD_READ, 29'h7ff, '0, '0);
    for (int k = 0; k < MAILBOX_ENTRIES - 3; k++) begin
      add_frame(CMD_STORE, ID_W'(32'h100 + k), 4'($urandom_range(0, 15)),
                {$urandom, $urandom});
    end
    add_frame(CMD_STORE, 29'h0aaa_aaaa, 4'd8, {$urandom, $urandom});
    add_frame(CMD_READ, 29'h0aaa_aaaa, '0, '0);

    for (int n = 0; n < 1200; n++) begin
      cmd = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      if (r < 75) id = id_pool[$urandom_range(0, id_pool.size() - 1)];
      else if (r < 87) id = 29'($urandom_range(0, 2047));
      else id = 29'($urandom);
      add_frame(cmd, id, 4'($urandom_range(0, 15)), {$urandom, $urandom});
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (frame_q.size() != 0 || s_axis_tvalid || pending_resp_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (MAILBOX_ENTRIES + 20) @(posedge clk_i);

    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
